[rtl/nec_ir_remote_decoder_assert.svh]
// Assertion macros for the NEC IR remote decoder.
// Included by the top level; no other dependencies.
`ifndef NEC_IR_REMOTE_DECODER_ASSERT_SVH
`define NEC_IR_REMOTE_DECODER_ASSERT_SVH

// Same-cycle implication under the async active-low reset.
`define NECIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("necir: implication check failed");

// Implication with a delayed consequent, under the same reset.
`define NECIR_ASSERT_IMP2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
    else $error("necir: two-cycle check failed");

`endif

[rtl/necir_pkg.sv]
// Shared types and constants for the NEC IR remote decoder.
// No dependencies; used by the front end, back end and top level.
package necir_pkg;

  typedef enum logic [1:0] {
    KIND_RISE = 2'd0,
    KIND_FALL = 2'd1,
    KIND_TICK = 2'd2,
    KIND_SCAN = 2'd3
  } kind_e;

  // Pulse-width class of a falling edge
  typedef enum logic [2:0] {
    WIN_NONE   = 3'd0,
    WIN_ZERO   = 3'd1,
    WIN_ONE    = 3'd2,
    WIN_REPEAT = 3'd3,
    WIN_LEADER = 3'd4
  } win_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] high_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic [7:0] repeat_count;
    logic       lead_seen;
    logic       frame_ready;
  } out_item_t;

  typedef struct packed {
    kind_e kind;
    win_e  win;
  } op_t;

  // Window bounds in us, all exclusive
  localparam logic [15:0] ZeroLo   = 16'd300;
  localparam logic [15:0] ZeroHi   = 16'd800;
  localparam logic [15:0] OneLo    = 16'd1400;
  localparam logic [15:0] OneHi    = 16'd1800;
  localparam logic [15:0] RepeatLo = 16'd2200;
  localparam logic [15:0] RepeatHi = 16'd2600;
  localparam logic [15:0] LeaderLo = 16'd4200;
  localparam logic [15:0] LeaderHi = 16'd4700;

  localparam logic [3:0] TickLimit = 4'd14;

  // Two-entry queues between stages
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

[rtl/necir_front.sv]
// Front end: accepts input beats, classifies the pulse width and queues ops.
// Depends on necir_pkg.
module necir_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  necir_pkg::in_item_t in_item_i,
  output logic               op_valid_o,
  output necir_pkg::op_t     op_o,
  input  logic               op_take_i
);

  necir_pkg::op_t                     mem_q [necir_pkg::QDepth];
  logic [necir_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [necir_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [necir_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                               wr_en;
  necir_pkg::op_t                     op_new;
  logic [15:0]                        t;

  assign t = in_item_i.high_time;

  always_comb begin
    op_new.kind = necir_pkg::kind_e'(in_item_i.kind);
    if (t > necir_pkg::ZeroLo && t < necir_pkg::ZeroHi) begin
      op_new.win = necir_pkg::WIN_ZERO;
    end else if (t > necir_pkg::OneLo && t < necir_pkg::OneHi) begin
      op_new.win = necir_pkg::WIN_ONE;
    end else if (t > necir_pkg::RepeatLo && t < necir_pkg::RepeatHi) begin
      op_new.win = necir_pkg::WIN_REPEAT;
    end else if (t > necir_pkg::LeaderLo && t < necir_pkg::LeaderHi) begin
      op_new.win = necir_pkg::WIN_LEADER;
    end else begin
      op_new.win = necir_pkg::WIN_NONE;
    end
  end

  assign full       = (cnt_q == necir_pkg::QCntW'(necir_pkg::QDepth));
  assign wr_en      = push && !full;
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (op_take_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en && !op_take_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && op_take_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

[rtl/necir_back.sv]
// Back end: applies queued ops to the receiver state, queues result beats.
// Depends on necir_pkg.
module necir_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                op_valid_i,
  input  necir_pkg::op_t      op_i,
  output logic                op_take_o,
  output logic                empty,
  input  logic                pop,
  output necir_pkg::out_item_t out_item_o
);

  logic [7:0]  addr_q;
  logic        leader_q, leader_d;
  logic        ready_q, ready_d;
  logic        rise_q, rise_d;
  logic [3:0]  tick_q, tick_d;
  logic [31:0] bits_q, bits_d;
  logic [7:0]  reps_q, reps_d;
  logic [7:0]  key;
  logic [7:0]  scan_key;
  logic [7:0]  fa, fna, fc, fnc;

  necir_pkg::out_item_t        mem_q [necir_pkg::QDepth];
  necir_pkg::out_item_t        res;
  logic [necir_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [necir_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                        res_full;
  logic                        rd_en;

  assign res_full  = (cnt_q == necir_pkg::QCntW'(necir_pkg::QDepth));
  assign op_take_o = op_valid_i && !res_full;
  assign empty     = (cnt_q == '0);
  assign rd_en     = pop && !empty;

  assign fa  = bits_q[31:24];
  assign fna = bits_q[23:16];
  assign fc  = bits_q[15:8];
  assign fnc = bits_q[7:0];

  always_comb begin
    scan_key = 8'd0;
    if (fa == ~fna && fa == addr_q && fc == ~fnc) begin
      scan_key = fc;
    end
  end

  always_comb begin
    leader_d = leader_q;
    ready_d  = ready_q;
    rise_d   = rise_q;
    tick_d   = tick_q;
    bits_d   = bits_q;
    reps_d   = reps_q;
    key      = 8'd0;
    unique case (op_i.kind)
      necir_pkg::KIND_RISE: begin
        rise_d = 1'b1;
      end
      necir_pkg::KIND_FALL: begin
        rise_d = 1'b0;
        if (rise_q) begin
          if (leader_q) begin
            case (op_i.win)
              necir_pkg::WIN_ZERO:   bits_d = {bits_q[30:0], 1'b0};
              necir_pkg::WIN_ONE:    bits_d = {bits_q[30:0], 1'b1};
              necir_pkg::WIN_REPEAT: begin
                reps_d = reps_q + 8'd1;
                tick_d = 4'd0;
              end
              default: ;
            endcase
          end else if (op_i.win == necir_pkg::WIN_LEADER) begin
            leader_d = 1'b1;
            reps_d   = 8'd0;
          end
        end
      end
      necir_pkg::KIND_TICK: begin
        if (leader_q) begin
          rise_d = 1'b0;
          if (tick_q == 4'd0) begin
            ready_d = 1'b1;
          end
          if (tick_q < necir_pkg::TickLimit) begin
            tick_d = tick_q + 4'd1;
          end else begin
            leader_d = 1'b0;
            tick_d   = 4'd0;
          end
        end
      end
      necir_pkg::KIND_SCAN: begin
        if (ready_q) begin
          key = scan_key;
          if (scan_key == 8'd0 || !leader_q) begin
            ready_d = 1'b0;
            reps_d  = 8'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.key_code     = key;
    res.repeat_count = reps_d;
    res.lead_seen    = leader_d;
    res.frame_ready  = ready_d;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (op_take_o && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!op_take_o && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= 8'd0;
      leader_q <= 1'b0;
      ready_q  <= 1'b0;
      rise_q   <= 1'b0;
      tick_q   <= 4'd0;
      bits_q   <= 32'd0;
      reps_q   <= 8'd0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      if (op_take_o) begin
        leader_q <= leader_d;
        ready_q  <= ready_d;
        rise_q   <= rise_d;
        tick_q   <= tick_d;
        bits_q   <= bits_d;
        reps_q   <= reps_d;
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_take_o) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

  assign out_item_o = mem_q[rd_ptr_q];

endmodule

[rtl/nec_ir_remote_decoder.sv]
// NEC IR remote decoder, top level. Depends on necir_pkg, necir_front, necir_back.
// A beat is registered in the op queue, then its result in the result queue.
// Throughput: one beat per cycle while results drain; front classifier and back
// state update meet at a two-entry op queue; results sit in a two-entry queue.
// Reset (rst_ni, async, active low) clears all flags, counters, frame bits, queues
// and the device address.
`include "nec_ir_remote_decoder_assert.svh"

module nec_ir_remote_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  necir_pkg::in_item_t in_item_i,
  output logic                empty,
  input  logic                pop,
  output necir_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  logic           op_valid;
  logic           op_take;
  necir_pkg::op_t op;

  necir_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_take_i  (op_take)
  );

  necir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_take_o   (op_take),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

  // Op queue can only fill up while it holds work for the back end
  `NECIR_ASSERT_IMP(a_full_has_op, clk_i, rst_ni, full, op_valid)
  // Back end never takes an op that is not there
  `NECIR_ASSERT_IMP(a_take_valid, clk_i, rst_ni, op_take, op_valid)
  // A beat into an idle pipe passes the op queue and can then be popped
  `NECIR_ASSERT_IMP2(a_idle_latency, clk_i, rst_ni, push && !full && !op_valid && empty, !empty)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for nec_ir_remote_decoder: feeds capture-timer events, mirrors
// the decoder in a behavioral model and compares every report. Needs necir_pkg and the RTL.
module tb_top;

  localparam int unsigned StallLimit = 1500;  // cycles without any beat
  localparam int unsigned LongHold   = 150;   // receiver hold-off to fill the block

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  necir_pkg::in_item_t  in_item_i   = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  necir_pkg::out_item_t out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [7:0]           cfg_wdata_i = '0;

  // decoder model state
  logic [7:0]  addr_model    = '0;
  logic        lead_model    = 1'b0;
  logic        ready_model   = 1'b0;
  logic        rise_model    = 1'b0;
  logic [3:0]  ticks_model   = '0;
  logic [31:0] frame_model   = '0;
  logic [7:0]  repeats_model = '0;

  necir_pkg::out_item_t pending_reports[$];

  int unsigned mismatches    = 0;
  int unsigned events_sent   = 0;
  int unsigned frames_sent   = 0;
  int unsigned keys_decoded  = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_request  = 1'b0;
  logic [7:0]  cfg_addr      = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nec_ir_remote_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  function automatic bit in_window(logic [15:0] t, logic [15:0] lo, logic [15:0] hi);
    return t > lo && t < hi;
  endfunction

  // Advances the model by one event and returns the report it produces.
  function automatic necir_pkg::out_item_t decode_event(necir_pkg::in_item_t ev);
    necir_pkg::out_item_t rep;
    logic [7:0]           a, na, c, nc;
    rep = '0;
    case (necir_pkg::kind_e'(ev.kind))
      necir_pkg::KIND_RISE: rise_model = 1'b1;
      necir_pkg::KIND_FALL: begin
        if (rise_model) begin
          if (lead_model) begin
            if (in_window(ev.high_time, necir_pkg::ZeroLo, necir_pkg::ZeroHi)) begin
              frame_model = {frame_model[30:0], 1'b0};
            end else if (in_window(ev.high_time, necir_pkg::OneLo, necir_pkg::OneHi)) begin
              frame_model = {frame_model[30:0], 1'b1};
            end else if (in_window(ev.high_time, necir_pkg::RepeatLo,
                                   necir_pkg::RepeatHi)) begin
              repeats_model = repeats_model + 8'd1;
              ticks_model   = '0;
            end
          end else if (in_window(ev.high_time, necir_pkg::LeaderLo,
                                 necir_pkg::LeaderHi)) begin
            lead_model    = 1'b1;
            repeats_model = '0;
          end
        end
        rise_model = 1'b0;
      end
      necir_pkg::KIND_TICK: begin
        if (lead_model) begin
          rise_model = 1'b0;
          if (ticks_model == '0) ready_model = 1'b1;
          if (ticks_model < necir_pkg::TickLimit) begin
            ticks_model = ticks_model + 4'd1;
          end else begin
            lead_model  = 1'b0;
            ticks_model = '0;
          end
        end
      end
      default: begin
        if (ready_model) begin
          {a, na, c, nc} = frame_model;
          if (a == ~na && a == addr_model && c == ~nc) rep.key_code = c;
          if (rep.key_code == '0 || !lead_model) begin
            ready_model   = 1'b0;
            repeats_model = '0;
          end
        end
      end
    endcase
    rep.repeat_count = repeats_model;
    rep.lead_seen    = lead_model;
    rep.frame_ready  = ready_model;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Beat monitor and report checker; also the no-progress watchdog.
  always @(posedge clk_i) begin
    necir_pkg::out_item_t want;
    bit                   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (pop && !empty) begin
        moved = 1'b1;
        if (pending_reports.size() == 0) begin
          $error("report beat with no event pending: %p", out_item_o);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("key_code", want.key_code, out_item_o.key_code);
          check_field("repeat_count", want.repeat_count, out_item_o.repeat_count);
          check_field("lead_seen", 8'(want.lead_seen), 8'(out_item_o.lead_seen));
          check_field("frame_ready", 8'(want.frame_ready), 8'(out_item_o.frame_ready));
          if (want.key_code != '0) keys_decoded++;
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        pending_reports.push_back(decode_event(in_item_i));
      end
      if (cfg_we_i) begin
        moved = 1'b1;
        addr_model = cfg_wdata_i;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no beat for %0d cycles, %0d reports pending",
                 StallLimit, pending_reports.size());
        $display("FAIL nec_ir_remote_decoder");
        $finish;
      end
    end
  end

  // Report side: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = LongHold;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called and returns at a falling edge; push stays high for a following beat.
  task automatic send_event(necir_pkg::kind_e kind, logic [15:0] width);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= '{kind: kind, high_time: width};
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    events_sent++;
  endtask

  task automatic send_pulse(logic [15:0] width);
    send_event(necir_pkg::KIND_RISE, 16'($urandom()));
    send_event(necir_pkg::KIND_FALL, width);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_address(logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_addr = value;
  endtask

  function automatic logic [15:0] pick_width(necir_pkg::win_e w);
    case (w)
      necir_pkg::WIN_ZERO:
        return 16'($urandom_range(necir_pkg::ZeroLo + 1, necir_pkg::ZeroHi - 1));
      necir_pkg::WIN_ONE:
        return 16'($urandom_range(necir_pkg::OneLo + 1, necir_pkg::OneHi - 1));
      necir_pkg::WIN_REPEAT:
        return 16'($urandom_range(necir_pkg::RepeatLo + 1, necir_pkg::RepeatHi - 1));
      necir_pkg::WIN_LEADER:
        return 16'($urandom_range(necir_pkg::LeaderLo + 1, necir_pkg::LeaderHi - 1));
      default: begin
        // window bounds are exclusive, so they must classify as nothing
        case ($urandom_range(9))
          0: return necir_pkg::ZeroLo;
          1: return necir_pkg::ZeroHi;
          2: return necir_pkg::OneLo;
          3: return necir_pkg::OneHi;
          4: return necir_pkg::RepeatLo;
          5: return necir_pkg::RepeatHi;
          6: return necir_pkg::LeaderLo;
          7: return necir_pkg::LeaderHi;
          default: return 16'($urandom());
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(logic [7:0] addr, logic [7:0] cmd, bit spoil,
                            int unsigned repeats, int unsigned ticks);
    logic [31:0] word;
    word = {addr, ~addr, cmd, ~cmd};
    if (spoil) word[$urandom_range(31)] ^= 1'b1;
    send_pulse(pick_width(necir_pkg::WIN_LEADER));
    for (int i = 31; i >= 0; i--) begin
      send_pulse(pick_width(word[i] ? necir_pkg::WIN_ONE : necir_pkg::WIN_ZERO));
    end
    repeat (ticks) send_event(necir_pkg::KIND_TICK, 16'($urandom()));
    send_event(necir_pkg::KIND_SCAN, 16'($urandom()));
    repeat (repeats) begin
      send_pulse(pick_width(necir_pkg::WIN_REPEAT));
      send_event(necir_pkg::KIND_TICK, 16'($urandom()));
      send_event(necir_pkg::KIND_SCAN, 16'($urandom()));
    end
    frames_sent++;
  endtask

  task automatic send_random_frame();
    logic [7:0]  addr, cmd;
    int unsigned ticks;
    addr = ($urandom_range(99) < 80) ? cfg_addr : 8'($urandom());
    case ($urandom_range(9))
      0:       cmd = 8'h00;
      1:       cmd = 8'hFF;
      default: cmd = 8'($urandom());
    endcase
    // mostly keep the leader alive, sometimes tick it out
    ticks = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(14, 18);
    send_frame(addr, cmd, $urandom_range(99) < 15, $urandom_range(0, 3), ticks);
  endtask

  task automatic send_noise();
    necir_pkg::kind_e kind;
    repeat ($urandom_range(1, 8)) begin
      kind = necir_pkg::kind_e'($urandom_range(3));
      send_event(kind, pick_width(necir_pkg::win_e'($urandom_range(4))));
    end
  endtask

  task automatic test_directed();
    send_event(necir_pkg::KIND_SCAN, 16'hFFFF);        // nothing captured yet
    send_event(necir_pkg::KIND_TICK, 16'h0000);        // tick while idle
    send_event(necir_pkg::KIND_FALL, 16'd4500);        // fall with no rise
    send_pulse(necir_pkg::LeaderLo);
    send_pulse(necir_pkg::LeaderHi);
    send_pulse(16'hFFFF);
    send_pulse(necir_pkg::LeaderHi - 1);               // leader
    send_pulse(16'h0000);
    send_pulse(necir_pkg::ZeroLo);
    send_pulse(necir_pkg::ZeroLo + 1);
    send_pulse(necir_pkg::OneHi - 1);
    send_pulse(necir_pkg::OneHi);
    send_pulse(necir_pkg::RepeatLo + 1);
    send_event(necir_pkg::KIND_TICK, 16'h5555);
    send_event(necir_pkg::KIND_SCAN, 16'hAAAA);
    wait_drained();
  endtask

  task automatic test_address_match();
    logic [7:0] addr;
    for (int k = 0; k < 2; k++) begin
      addr = (k == 0) ? 8'hFF : 8'h00;
      write_address(addr);
      send_frame(addr, (k == 0) ? 8'h00 : 8'hFF, 1'b0, 1, 1);
      send_frame(~addr, 8'($urandom()), 1'b0, 0, 16);
      // valid key, but the leader times out before the scan
      send_frame(addr, 8'($urandom_range(1, 255)), 1'b0, 0, 16);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (40) send_noise();
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned sidle, int unsigned ridle,
                                     int unsigned budget);
    int unsigned stop_at;
    write_address(8'($urandom()));
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    stop_at = events_sent + budget;
    while (events_sent < stop_at) begin
      if ($urandom_range(99) < 75) send_random_frame();
      else send_noise();
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_address_match();
    test_backpressure();
    test_random_traffic(20, 57, 160);
    test_random_traffic(57, 20, 160);
    test_random_traffic(0, 0, 160);
    $display("covered %0d events in %0d frames, %0d keys decoded; addresses 00, FF, random",
             events_sent, frames_sent, keys_decoded);
    $display("stall phases, a long report hold-off and %0d mismatches", mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS nec_ir_remote_decoder");
    end else begin
      $display("FAIL nec_ir_remote_decoder");
    end
    $finish;
  end

endmodule
